// ===== rtl/core/line_intersection_heatmap_core_macros.svh =====
// Assertion macros for the heat map core RTL, included by the back end.
`ifndef LINE_INTERSECTION_HEATMAP_CORE_MACROS_SVH
`define LINE_INTERSECTION_HEATMAP_CORE_MACROS_SVH

// Same-cycle implication, idle while reset is high.
`define LIHM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lihm assertion failed (same cycle)");

// Next-cycle implication, idle while reset is high.
`define LIHM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lihm assertion failed (next cycle)");

`endif

// ===== rtl/core/lihm_pkg.sv =====
// Shared types, codes and constants of the line intersection heat map core.
package lihm_pkg;

   localparam int DEF_Z_BINS = 256;
   localparam int DEF_X_BINS = 256;
   localparam int MAX_ADDR_W = 24;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_Z_LOW        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Z_HIGH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_LOW        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_COS_SQ = 3'd4;

   localparam logic [31:0] RST_Z_LOW        = 32'd0;
   localparam logic [31:0] RST_Z_HIGH       = 32'd65536;
   localparam logic [31:0] RST_X_LOW        = 32'd0;
   localparam logic [31:0] RST_X_HIGH       = 32'd65536;
   localparam logic [15:0] RST_ANGLE_COS_SQ = 16'd63560;

   localparam logic [1:0] OP_ACCUM      = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;
   // spare code, handled as a plain read
   localparam logic [1:0] OP_READ_ALT   = 2'd3;

   // shared serial arithmetic unit
   localparam int MUL_W     = 146;
   localparam int MUL_B_W   = 66;
   localparam int DIV_W     = 64;
   localparam int CNT_W     = 7;
   localparam logic [CNT_W-1:0] MUL_STEPS = 7'd66;
   localparam logic [CNT_W-1:0] DIV_STEPS = 7'd64;

   localparam int Q_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_ADDED, ST_CLOSE, ST_PARALLEL, ST_INSIDE, ST_OFF_MAP, ST_READ
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE, CMD_ADD, CMD_READ, CMD_CLEAR
   } cmd_kind_type;

   typedef enum logic [3:0] {
      F_IDLE, F_DOT, F_FA, F_FB, F_LHS, F_T2, F_RHS, F_CMP,
      F_ZDIV, F_ZCHK, F_ZBIN, F_XMUL, F_XCHK, F_XBIN, F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR, B_IDLE, B_READ, B_WRITE
   } back_state_type;

   typedef struct packed {
      logic signed [31:0] z_low;
      logic signed [31:0] z_high;
      logic signed [31:0] x_low;
      logic signed [31:0] x_high;
      logic [15:0]        angle_cos_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] slope_a;
      logic signed [31:0] icpt_a;
      logic signed [31:0] zlo_a;
      logic signed [31:0] zhi_a;
      logic signed [31:0] slope_b;
      logic signed [31:0] icpt_b;
      logic signed [31:0] zlo_b;
      logic signed [31:0] zhi_b;
      logic [15:0]        weight;
      logic [7:0]         bin_z;
      logic [7:0]         bin_x;
   } item_type;

   // one unit of work for the count memory side
   typedef struct packed {
      status_type              status;
      cmd_kind_type            kind;
      logic [MAX_ADDR_W-1:0]   addr;
      logic [15:0]             weight;
      logic [7:0]              hit_z;
      logic [7:0]              hit_x;
   } cmd_type;

endpackage

// ===== rtl/core/lihm_front.sv =====
// Front end: takes items, runs the angle test, crossing and bin math, issues commands.
module lihm_front
   import lihm_pkg::*;
#(
   parameter int MAP_Z_BINS = DEF_Z_BINS,
   parameter int MAP_X_BINS = DEF_X_BINS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     clearing,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [1:0] req_op,
   input  item_type req_item,
   output logic     cmd_valid,
   input  logic     cmd_ready,
   output cmd_type  cmd
);

   localparam int ADDR_W = $clog2(MAP_Z_BINS * MAP_X_BINS);

   front_state_type state_ff, state_in;
   item_type        it_ff;
   cmd_type         cmd_ff;
   cmd_type         rd_cmd_w;

   logic             phase_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [MUL_W-1:0] acc_ff, mula_ff;
   logic [MUL_B_W-1:0] mulb_ff;
   logic [DIV_W:0]   rem_ff;
   logic [DIV_W-1:0] quo_ff, den_ff;

   logic [64:0]      adot_ff;
   logic [63:0]      fa_ff, fb_ff;
   logic [129:0]     t1_ff;
   logic [MUL_W-1:0] t2_ff;
   logic signed [63:0] z_ff, x_ff;
   logic [15:0]      iz_ff;

   logic             start_w, is_mul_w, done_w;
   logic [CNT_W-1:0] steps_w;
   logic [MUL_W-1:0] op_a_w;
   logic [MUL_B_W-1:0] op_b_w;
   logic [DIV_W-1:0] div_num_w, div_den_w;

   logic [MUL_W-1:0] acc_nx;
   logic [DIV_W:0]   rem_sh, rem_nx;
   logic             div_ge;

   logic [31:0] abs_ma, abs_mb;
   logic signed [32:0] diff_c, diff_m;
   logic [32:0] abs_dc, abs_dm;
   logic [63:0] abs_z;
   logic signed [63:0] zla, zha, zlb, zhb, zl, zh, xl, xh, ca64;
   logic [32:0] zoff, xoff;
   logic [63:0] num_zb, num_xb;

   logic signed [65:0] dot_w;
   logic [64:0] adot_w;
   logic signed [63:0] z_w, x_w;
   logic signed [96:0] sp_w;
   logic close_w, par_w, inside_w, zout_w, xout_w;
   logic [ADDR_W-1:0] add_addr_w, rd_addr_w;
   logic rd_in_range;

   function automatic cmd_type reject(input status_type s);
      cmd_type c;
      c        = '0;
      c.status = s;
      c.kind   = CMD_NONE;
      return c;
   endfunction

   // operand conditioning
   assign abs_ma = it_ff.slope_a[31] ? 32'(-33'(it_ff.slope_a)) : 32'(it_ff.slope_a);
   assign abs_mb = it_ff.slope_b[31] ? 32'(-33'(it_ff.slope_b)) : 32'(it_ff.slope_b);
   assign diff_c = 33'(it_ff.icpt_b) - 33'(it_ff.icpt_a);
   assign diff_m = 33'(it_ff.slope_a) - 33'(it_ff.slope_b);
   assign abs_dc = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
   assign abs_dm = diff_m[32] ? 33'(-diff_m) : 33'(diff_m);
   assign abs_z  = z_ff[63] ? 64'(-z_ff) : 64'(z_ff);

   assign zla  = 64'(it_ff.zlo_a);
   assign zha  = 64'(it_ff.zhi_a);
   assign zlb  = 64'(it_ff.zlo_b);
   assign zhb  = 64'(it_ff.zhi_b);
   assign ca64 = 64'(it_ff.icpt_a);
   assign zl   = 64'(cfg.z_low);
   assign zh   = 64'(cfg.z_high);
   assign xl   = 64'(cfg.x_low);
   assign xh   = 64'(cfg.x_high);

   assign zoff   = 33'(z_ff - zl);
   assign xoff   = 33'(x_ff - xl);
   assign num_zb = 64'(zoff) * 64'(MAP_Z_BINS);
   assign num_xb = 64'(xoff) * 64'(MAP_X_BINS);

   // result shaping
   assign dot_w  = (it_ff.slope_a[31] ^ it_ff.slope_b[31] ? -66'(acc_ff[63:0])
                                                         : 66'(acc_ff[63:0]))
                   + 66'sh1_0000_0000;
   assign adot_w = dot_w[65] ? 65'(-dot_w) : 65'(dot_w);

   assign z_w = (diff_c[32] ^ diff_m[32])
                ? -$signed(quo_ff) - 64'(rem_ff != '0)
                : $signed(quo_ff);

   assign sp_w = (z_ff[63] ^ it_ff.slope_a[31]) ? -97'(acc_ff[95:0]) : 97'(acc_ff[95:0]);
   assign x_w  = 64'(sp_w >>> 16) + ca64;

   assign close_w  = {t1_ff, 16'h0000} > t2_ff;
   assign par_w    = it_ff.slope_a == it_ff.slope_b;
   assign inside_w = (z_ff >= zla && z_ff <= zha) || (z_ff >= zlb && z_ff <= zhb);
   assign zout_w   = !(zh > zl && z_ff >= zl && z_ff < zh);
   assign xout_w   = !(xh > xl && x_ff >= xl && x_ff < xh);

   assign add_addr_w = ADDR_W'(iz_ff) * ADDR_W'(MAP_X_BINS) + ADDR_W'(quo_ff);
   assign rd_in_range = 32'(req_item.bin_z) < 32'(MAP_Z_BINS) &&
                        32'(req_item.bin_x) < 32'(MAP_X_BINS);
   assign rd_addr_w = ADDR_W'(req_item.bin_z) * ADDR_W'(MAP_X_BINS) +
                      ADDR_W'(req_item.bin_x);

   // command for a read item, formed from the incoming transfer
   always_comb begin
      rd_cmd_w       = reject(ST_READ);
      rd_cmd_w.hit_z = req_item.bin_z;
      rd_cmd_w.hit_x = req_item.bin_x;
      rd_cmd_w.addr  = MAX_ADDR_W'(rd_addr_w);
      if (!rd_in_range) begin
         rd_cmd_w.kind = CMD_NONE;
      end else if (req_op == OP_READ_CLEAR) begin
         rd_cmd_w.kind = CMD_CLEAR;
      end else begin
         rd_cmd_w.kind = CMD_READ;
      end
   end

   // serial shift-add multiply and restoring divide steps
   assign acc_nx = mulb_ff[0] ? acc_ff + mula_ff : acc_ff;
   assign rem_sh = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign div_ge = rem_sh >= {1'b0, den_ff};
   assign rem_nx = div_ge ? rem_sh - {1'b0, den_ff} : rem_sh;

   assign steps_w = is_mul_w ? MUL_STEPS : DIV_STEPS;
   assign done_w  = phase_ff && (cnt_ff == steps_w);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = (req_op == OP_ACCUM) ? F_DOT : F_PUSH;
            end
         end
         F_DOT:  if (done_w) state_in = F_FA;
         F_FA:   if (done_w) state_in = F_FB;
         F_FB:   if (done_w) state_in = F_LHS;
         F_LHS:  if (done_w) state_in = F_T2;
         F_T2:   if (done_w) state_in = F_RHS;
         F_RHS:  if (done_w) state_in = F_CMP;
         F_CMP:  state_in = (close_w || par_w) ? F_PUSH : F_ZDIV;
         F_ZDIV: if (done_w) state_in = F_ZCHK;
         F_ZCHK: state_in = (inside_w || zout_w) ? F_PUSH : F_ZBIN;
         F_ZBIN: if (done_w) state_in = F_XMUL;
         F_XMUL: if (done_w) state_in = F_XCHK;
         F_XCHK: state_in = xout_w ? F_PUSH : F_XBIN;
         F_XBIN: if (done_w) state_in = F_PUSH;
         F_PUSH: if (cmd_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs and arithmetic operand selection
   always_comb begin
      req_ready = (state_ff == F_IDLE) && !clearing;
      cmd_valid = (state_ff == F_PUSH);
      is_mul_w  = 1'b0;
      start_w   = 1'b0;
      op_a_w    = '0;
      op_b_w    = '0;
      div_num_w = '0;
      div_den_w = '0;
      case (state_ff)
         F_DOT: begin
            is_mul_w = 1'b1;
            op_a_w   = MUL_W'(abs_ma);
            op_b_w   = MUL_B_W'(abs_mb);
         end
         F_FA: begin
            is_mul_w = 1'b1;
            op_a_w   = MUL_W'(abs_ma);
            op_b_w   = MUL_B_W'(abs_ma);
         end
         F_FB: begin
            is_mul_w = 1'b1;
            op_a_w   = MUL_W'(abs_mb);
            op_b_w   = MUL_B_W'(abs_mb);
         end
         F_LHS: begin
            is_mul_w = 1'b1;
            op_a_w   = MUL_W'(adot_ff);
            op_b_w   = MUL_B_W'(adot_ff);
         end
         F_T2: begin
            is_mul_w = 1'b1;
            op_a_w   = MUL_W'(fa_ff);
            op_b_w   = MUL_B_W'(fb_ff);
         end
         F_RHS: begin
            is_mul_w = 1'b1;
            op_a_w   = t2_ff;
            op_b_w   = MUL_B_W'(cfg.angle_cos_sq);
         end
         F_XMUL: begin
            is_mul_w = 1'b1;
            op_a_w   = MUL_W'(abs_z);
            op_b_w   = MUL_B_W'(abs_ma);
         end
         F_ZDIV: begin
            div_num_w = 64'({abs_dc, 16'h0000});
            div_den_w = 64'(abs_dm);
         end
         F_ZBIN: begin
            div_num_w = num_zb;
            div_den_w = 64'(zh - zl);
         end
         F_XBIN: begin
            div_num_w = num_xb;
            div_den_w = 64'(xh - xl);
         end
         default: begin
         end
      endcase
      case (state_ff)
         F_DOT, F_FA, F_FB, F_LHS, F_T2, F_RHS, F_XMUL, F_ZDIV, F_ZBIN, F_XBIN:
            start_w = !phase_ff;
         default: start_w = 1'b0;
      endcase
   end

   assign cmd = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_w) begin
            phase_ff <= 1'b1;
         end else if (done_w) begin
            phase_ff <= 1'b0;
         end
      end
   end

   // arithmetic unit registers
   always_ff @(posedge clock) begin
      if (start_w) begin
         cnt_ff  <= '0;
         acc_ff  <= '0;
         mula_ff <= op_a_w;
         mulb_ff <= op_b_w;
         rem_ff  <= '0;
         quo_ff  <= div_num_w;
         den_ff  <= div_den_w;
      end else if (phase_ff && !done_w) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (is_mul_w) begin
            acc_ff  <= acc_nx;
            mula_ff <= {mula_ff[MUL_W-2:0], 1'b0};
            mulb_ff <= {1'b0, mulb_ff[MUL_B_W-1:1]};
         end else begin
            rem_ff <= rem_nx;
            quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
         end
      end
   end

   // item, intermediate results and outgoing command
   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               it_ff  <= req_item;
               cmd_ff <= rd_cmd_w;
            end
         end
         F_DOT: if (done_w) adot_ff <= adot_w;
         F_FA:  if (done_w) fa_ff <= 64'h1_0000_0000 + acc_ff[63:0];
         F_FB:  if (done_w) fb_ff <= 64'h1_0000_0000 + acc_ff[63:0];
         F_LHS: if (done_w) t1_ff <= acc_ff[129:0];
         F_T2:  if (done_w) t2_ff <= acc_ff;
         F_RHS: if (done_w) t2_ff <= acc_ff;
         F_CMP: begin
            if (close_w) begin
               cmd_ff <= reject(ST_CLOSE);
            end else if (par_w) begin
               cmd_ff <= reject(ST_PARALLEL);
            end
         end
         F_ZDIV: if (done_w) z_ff <= z_w;
         F_ZCHK: begin
            if (inside_w) begin
               cmd_ff <= reject(ST_INSIDE);
            end else if (zout_w) begin
               cmd_ff <= reject(ST_OFF_MAP);
            end
         end
         F_ZBIN: if (done_w) iz_ff <= quo_ff[15:0];
         F_XMUL: if (done_w) x_ff <= x_w;
         F_XCHK: if (xout_w) cmd_ff <= reject(ST_OFF_MAP);
         F_XBIN: begin
            if (done_w) begin
               cmd_ff.status <= ST_ADDED;
               cmd_ff.kind   <= CMD_ADD;
               cmd_ff.addr   <= MAX_ADDR_W'(add_addr_w);
               cmd_ff.weight <= it_ff.weight;
               cmd_ff.hit_z  <= iz_ff[7:0];
               cmd_ff.hit_x  <= quo_ff[7:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/lihm_queue.sv =====
// Short command queue between the front end and the count memory side.
module lihm_queue
   import lihm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   localparam int PTR_W = $clog2(Q_DEPTH);

   cmd_type            buf_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     cnt_ff;
   logic               push, pop;

   assign in_ready  = cnt_ff != (PTR_W+1)'(Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_cmd   = buf_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ptr_ff] <= in_cmd;
   end

endmodule

// ===== rtl/core/lihm_back.sv =====
// Back end: count memory with clearing sweep, read-modify-write and the result register.
module lihm_back
   import lihm_pkg::*;
#(
   parameter int MAP_Z_BINS = DEF_Z_BINS,
   parameter int MAP_X_BINS = DEF_X_BINS
) (
   input  logic        clock,
   input  logic        reset,
   output logic        clearing,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_count,
   output logic [7:0]  rsp_hit_z,
   output logic [7:0]  rsp_hit_x
);

`include "line_intersection_heatmap_core_macros.svh"

   localparam int MAP_DEPTH = MAP_Z_BINS * MAP_X_BINS;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);

   back_state_type    state_ff, state_in;
   cmd_type           cur_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [31:0]       mem [MAP_DEPTH];
   logic [31:0]       rdata_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [31:0]       rsp_count_ff;
   logic [7:0]        rsp_hit_z_ff, rsp_hit_x_ff;

   logic              out_free, load_out, mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [31:0]       mem_wdata, count_w;
   logic [32:0]       sum_w;
   logic [31:0]       sat_w;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sum_w    = {1'b0, rdata_ff} + 33'(cur_ff.weight);
   assign sat_w    = sum_w[32] ? '1 : sum_w[31:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_cnt_ff == ADDR_W'(MAP_DEPTH - 1)) state_in = B_IDLE;
         B_IDLE:  if (cmd_valid) state_in = B_READ;
         B_READ:  state_in = B_WRITE;
         B_WRITE: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      clearing  = (state_ff == B_CLEAR);
      cmd_ready = (state_ff == B_IDLE);
      load_out  = (state_ff == B_WRITE) && out_free;
      mem_we    = 1'b0;
      mem_waddr = cur_ff.addr[ADDR_W-1:0];
      mem_wdata = '0;
      count_w   = '0;
      case (cur_ff.kind)
         CMD_ADD: begin
            count_w   = sat_w;
            mem_wdata = sat_w;
            mem_we    = load_out;
         end
         CMD_READ:  count_w = rdata_ff;
         CMD_CLEAR: begin
            count_w = rdata_ff;
            mem_we  = load_out;
         end
         default: count_w = '0;
      endcase
      if (state_ff == B_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) cur_ff <= cmd;
      if (load_out) begin
         rsp_status_ff <= cur_ff.status;
         rsp_count_ff  <= count_w;
         rsp_hit_z_ff  <= cur_ff.hit_z;
         rsp_hit_x_ff  <= cur_ff.hit_x;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[cur_ff.addr[ADDR_W-1:0]];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_hit_z  = rsp_hit_z_ff;
   assign rsp_hit_x  = rsp_hit_x_ff;

   `LIHM_ASSERT_IMP(a_clear_quiet, clock, reset, state_ff == B_CLEAR, !rsp_valid_ff && !cmd_ready)
   `LIHM_ASSERT_NXT(a_add_keeps_weight, clock, reset, load_out && cur_ff.kind == CMD_ADD, rsp_count_ff >= 32'($past(cur_ff.weight)))
   `LIHM_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_ADDED && rsp_status_ff != ST_READ, rsp_count_ff == '0 && rsp_hit_z_ff == '0 && rsp_hit_x_ff == '0)

endmodule

// ===== rtl/core/line_intersection_heatmap_core.sv =====
// Top level of the line intersection heat map core: ports, config registers, wiring.
// After reset the count map is swept to zero, one bin per cycle, over all MAP_Z_BINS *
// MAP_X_BINS bins (65536 by default); no item is taken during that sweep. A read item
// skips the arithmetic and goes straight to the command queue. An accumulate item runs
// seven multiplies and three divides in the front end on one bit-serial shift-add /
// restoring-divide unit, which sets the rate; the count memory side then does its
// read-modify-write through its read and write states. A two-entry command queue lets
// the front end start the next item while the memory side and the result register wait on the consumer.
module line_intersection_heatmap_core
   import lihm_pkg::*;
#(
   parameter int MAP_Z_BINS = DEF_Z_BINS,
   parameter int MAP_X_BINS = DEF_X_BINS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // slope_a, icpt_a, zlo_a, zhi_a, slope_b, icpt_b, zlo_b, zhi_b, weight, bin_z, bin_x
   input  logic [287:0]         req_tdata,
   // op
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // count, hit_z_bin, hit_x_bin
   output logic [47:0]          rsp_tdata,
   // status
   output logic [2:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type     cfg_ff;
   item_type    item;
   cmd_type     f_cmd, q_cmd;
   logic        f_cmd_valid, f_cmd_ready, q_cmd_valid, q_cmd_ready, clearing;
   logic [2:0]  status;
   logic [31:0] count;
   logic [7:0]  hit_z, hit_x;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.z_low        <= RST_Z_LOW;
         cfg_ff.z_high       <= RST_Z_HIGH;
         cfg_ff.x_low        <= RST_X_LOW;
         cfg_ff.x_high       <= RST_X_HIGH;
         cfg_ff.angle_cos_sq <= RST_ANGLE_COS_SQ;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_Z_LOW:        cfg_ff.z_low        <= csr_data;
            REG_Z_HIGH:       cfg_ff.z_high       <= csr_data;
            REG_X_LOW:        cfg_ff.x_low        <= csr_data;
            REG_X_HIGH:       cfg_ff.x_high       <= csr_data;
            REG_ANGLE_COS_SQ: cfg_ff.angle_cos_sq <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign item.slope_a = req_tdata[31:0];
   assign item.icpt_a  = req_tdata[63:32];
   assign item.zlo_a   = req_tdata[95:64];
   assign item.zhi_a   = req_tdata[127:96];
   assign item.slope_b = req_tdata[159:128];
   assign item.icpt_b  = req_tdata[191:160];
   assign item.zlo_b   = req_tdata[223:192];
   assign item.zhi_b   = req_tdata[255:224];
   assign item.weight  = req_tdata[271:256];
   assign item.bin_z   = req_tdata[279:272];
   assign item.bin_x   = req_tdata[287:280];

   lihm_front #(
      .MAP_Z_BINS(MAP_Z_BINS),
      .MAP_X_BINS(MAP_X_BINS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .clearing  (clearing),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_item  (item),
      .cmd_valid (f_cmd_valid),
      .cmd_ready (f_cmd_ready),
      .cmd       (f_cmd)
   );

   lihm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_cmd_valid),
      .in_ready  (f_cmd_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_cmd_valid),
      .out_ready (q_cmd_ready),
      .out_cmd   (q_cmd)
   );

   lihm_back #(
      .MAP_Z_BINS(MAP_Z_BINS),
      .MAP_X_BINS(MAP_X_BINS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .cmd_valid  (q_cmd_valid),
      .cmd_ready  (q_cmd_ready),
      .cmd        (q_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (status),
      .rsp_count  (count),
      .rsp_hit_z  (hit_z),
      .rsp_hit_x  (hit_x)
   );

   assign rsp_tdata = {hit_x, hit_z, count};
   assign rsp_tuser = status;

endmodule
